// ----- rtl/u8sb_pkg.sv -----
`default_nettype none

package u8sb_pkg;

  // reverse map geometry
  localparam int MapDepth = 128;
  localparam int MapAw    = (MapDepth > 1) ? $clog2(MapDepth) : 1;
  localparam int MapCntW  = $clog2(MapDepth + 1);

  // decoded code point width (up to 21 bits from a four byte sequence)
  localparam int CpW = 21;

  // charset modes, a mode of 3 acts as ascii only
  localparam logic [1:0] ModeTable    = 2'd0;
  localparam logic [1:0] ModeIdentity = 2'd1;
  localparam logic [1:0] ModeAscii    = 2'd2;

  // configuration register indexes
  localparam logic CfgCharsetMode = 1'b0;
  localparam logic CfgMapCount    = 1'b1;

  // request types
  localparam logic ReqMapWrite = 1'b0;
  localparam logic ReqText     = 1'b1;

  localparam logic [7:0]     SubstByte   = 8'h3F;
  localparam logic [CpW-1:0] AsciiLimit  = CpW'(32'h80);
  localparam logic [CpW-1:0] Latin1Max   = CpW'(32'hFF);
  localparam logic [CpW-1:0] BmpMax      = CpW'(32'hFFFF);

  // utf-8 lead byte patterns
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Val  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Val  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Val  = 8'hF0;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  text_byte;
    logic        text_end;
    logic [6:0]  entry_index;
    logic [15:0] entry_code_point;
    logic [7:0]  entry_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [MapAw-1:0] idx;
    logic [15:0]      key;
    logic [7:0]       val;
  } map_wr_t;

  typedef struct packed {
    logic           start;
    logic [CpW-1:0] cp;
    logic [1:0]     mode;
    logic [7:0]     count;
  } lk_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] code;
  } lk_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_LOOKUP
  } ctl_state_e;

  typedef enum logic [1:0] {
    L_IDLE,
    L_CHECK,
    L_READ
  } lk_state_e;

endpackage

`default_nettype wire

// ----- rtl/u8sb_lookup.sv -----
`default_nettype none

module u8sb_lookup
  import u8sb_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire map_wr_t map_wr_i,
  input  wire lk_req_t req_i,
  output lk_rsp_t      rsp_o
);

  lk_state_e state_q, state_d;

  logic               done_q, done_d;
  logic [7:0]         code_q, code_d;
  logic [CpW-1:0]     cp_q, cp_d;
  logic [MapCntW-1:0] lo_q, lo_d;
  logic [MapCntW-1:0] hi_q, hi_d;
  logic [MapAw-1:0]   mid_q, mid_d;
  logic [MapAw-1:0]   mid_calc;
  logic [MapCntW:0]   lo_hi_sum;
  logic [MapCntW-1:0] hi_init;
  logic               rd_en;
  logic [23:0]        rd_data_q;
  logic [15:0]        probe_key;
  logic               need_search;

  logic [23:0] map_mem [MapDepth];

  always_ff @(posedge clk_i) begin
    if (map_wr_i.en) begin
      map_mem[map_wr_i.idx] <= {map_wr_i.key, map_wr_i.val};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= map_mem[mid_calc];
    end
  end

  assign lo_hi_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_calc  = MapAw'(lo_hi_sum >> 1);
  assign probe_key = rd_data_q[23:8];
  assign hi_init   = (int'(req_i.count) > MapDepth) ? MapCntW'(MapDepth)
                                                    : MapCntW'(req_i.count);

  assign need_search = (req_i.cp >= AsciiLimit) && (req_i.mode == ModeTable) &&
                       (req_i.cp <= BmpMax);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE: begin
        if (req_i.start && need_search) begin
          state_d = L_CHECK;
        end
      end
      L_CHECK: begin
        state_d = (lo_q < hi_q) ? L_READ : L_IDLE;
      end
      L_READ: begin
        state_d = (cp_q[15:0] == probe_key) ? L_IDLE : L_CHECK;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_comb begin
    done_d = done_q;
    code_d = code_q;
    cp_d   = cp_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    mid_d  = mid_q;
    rd_en  = 1'b0;
    unique case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          cp_d   = req_i.cp;
          done_d = 1'b1;
          lo_d   = '0;
          hi_d   = hi_init;
          priority if (req_i.cp < AsciiLimit) begin
            code_d = req_i.cp[7:0];
          end else if (req_i.mode == ModeIdentity) begin
            code_d = (req_i.cp <= Latin1Max) ? req_i.cp[7:0] : SubstByte;
          end else if (!need_search) begin
            code_d = SubstByte;
          end else begin
            done_d = 1'b0;
          end
        end
      end
      L_CHECK: begin
        if (lo_q < hi_q) begin
          mid_d = mid_calc;
          rd_en = 1'b1;
        end else begin
          done_d = 1'b1;
          code_d = SubstByte;
        end
      end
      L_READ: begin
        priority if (cp_q[15:0] < probe_key) begin
          hi_d = MapCntW'(mid_q);
        end else if (cp_q[15:0] > probe_key) begin
          lo_d = MapCntW'(mid_q) + MapCntW'(1);
        end else begin
          done_d = 1'b1;
          code_d = rd_data_q[7:0];
        end
      end
      default: begin
        done_d = done_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    cp_q   <= cp_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.code = code_q;

endmodule

`default_nettype wire

// ----- rtl/utf8_to_single_byte_charset_core.sv -----
`default_nettype none

// a transfer that completes a code point runs through decode and lookup before out_valid_o
// rises; table mode does a binary search of up to 8 probes
// input: a map write or a byte that only extends a sequence leaves in_ready_o high; a completing
// byte holds in_ready_o low until its result is loaded, and a cut-short text end repeats
// decode and lookup for each of up to 3 results
// reset: identity mode, map count 0, pending text cleared; map contents stay undefined

module utf8_to_single_byte_charset_core
  import u8sb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic      cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  ctl_state_e state_q, state_d;

  logic [3:0][7:0] buf_q, buf_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [1:0]      needed_q, needed_d;
  logic            last_q, last_d;
  logic            end_q, end_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  logic [1:0]      mode_q;
  logic [7:0]      count_q;

  logic            in_acc;
  logic            text_acc;
  logic            go_decode;
  logic [1:0]      needed_c;
  logic            out_free;
  logic            out_load;
  logic [CpW-1:0]  dec_cp;
  logic [2:0]      dec_adv;
  map_wr_t         map_wr;
  lk_req_t         lk_req;
  lk_rsp_t         lk_rsp;

  function automatic logic [1:0] extra_bytes(input logic [7:0] b);
    logic [1:0] n;
    priority if ((b & Lead2Mask) == Lead2Val) begin
      n = 2'd1;
    end else if ((b & Lead3Mask) == Lead3Val) begin
      n = 2'd2;
    end else if ((b & Lead4Mask) == Lead4Val) begin
      n = 2'd3;
    end else begin
      n = 2'd0;
    end
    return n;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign text_acc    = in_acc && (in_data_i.req_type == ReqText);
  assign needed_c    = extra_bytes(in_data_i.text_byte);
  assign go_decode   = in_data_i.text_end ||
                       ((cnt_q == 3'd0) ? (needed_c == 2'd0) : (cnt_q >= {1'b0, needed_q}));
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  // decode one sequence from the head of the buffer; a lead byte that lacks
  // enough following bytes decodes as itself
  always_comb begin
    dec_cp  = CpW'(buf_q[0]);
    dec_adv = 3'd1;
    priority if (buf_q[0] < 8'h80) begin
      dec_adv = 3'd1;
    end else if (((buf_q[0] & Lead2Mask) == Lead2Val) && (cnt_q >= 3'd2)) begin
      dec_cp  = CpW'({buf_q[0][4:0], buf_q[1][5:0]});
      dec_adv = 3'd2;
    end else if (((buf_q[0] & Lead3Mask) == Lead3Val) && (cnt_q >= 3'd3)) begin
      dec_cp  = CpW'({buf_q[0][3:0], buf_q[1][5:0], buf_q[2][5:0]});
      dec_adv = 3'd3;
    end else if (((buf_q[0] & Lead4Mask) == Lead4Val) && (cnt_q >= 3'd4)) begin
      dec_cp  = {buf_q[0][2:0], buf_q[1][5:0], buf_q[2][5:0], buf_q[3][5:0]};
      dec_adv = 3'd4;
    end else begin
      dec_adv = 3'd1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (text_acc && go_decode) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (lk_rsp.done && out_free) begin
          state_d = last_q ? S_IDLE : S_DECODE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    buf_d        = buf_q;
    cnt_d        = cnt_q;
    needed_d     = needed_q;
    last_d       = last_q;
    end_d        = end_q;
    out_load     = 1'b0;
    lk_req.start = 1'b0;
    lk_req.cp    = dec_cp;
    lk_req.mode  = mode_q;
    lk_req.count = count_q;
    map_wr.en    = in_acc && (in_data_i.req_type == ReqMapWrite) &&
                   (int'(in_data_i.entry_index) < MapDepth);
    map_wr.idx   = MapAw'(in_data_i.entry_index);
    map_wr.key   = in_data_i.entry_code_point;
    map_wr.val   = in_data_i.entry_byte;
    unique case (state_q)
      S_IDLE: begin
        if (text_acc) begin
          buf_d[cnt_q[1:0]] = in_data_i.text_byte;
          cnt_d             = cnt_q + 3'd1;
          end_d             = in_data_i.text_end;
          if (go_decode) begin
            needed_d = 2'd0;
          end else if (cnt_q == 3'd0) begin
            needed_d = needed_c;
          end
        end
      end
      S_DECODE: begin
        lk_req.start = 1'b1;
        buf_d        = buf_q >> {dec_adv, 3'b000};
        cnt_d        = cnt_q - dec_adv;
        last_d       = (cnt_q == dec_adv);
      end
      S_LOOKUP: begin
        out_load = lk_rsp.done && out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d     = 1'b1;
      out_d.out_byte  = lk_rsp.code;
      out_d.run_last  = last_q;
      out_d.text_done = last_q && end_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  u8sb_lookup u_lookup (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .map_wr_i (map_wr),
    .req_i    (lk_req),
    .rsp_o    (lk_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 3'd0;
      needed_q    <= 2'd0;
      out_valid_q <= 1'b0;
      mode_q      <= ModeIdentity;
      count_q     <= 8'd0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      needed_q    <= needed_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgCharsetMode: mode_q  <= cfg_data_i[1:0];
          CfgMapCount:    count_q <= cfg_data_i;
          default:        mode_q  <= mode_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    last_q <= last_d;
    end_q  <= end_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- tb/utf8_to_single_byte_charset_core_tb.sv -----
module utf8_to_single_byte_charset_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8sb_pkg::*;

  localparam int StallLimit   = 2000;
  localparam int SettleCycles = 100;
  localparam logic [1:0] ModeSpare = 2'd3;

  typedef enum logic [1:0] {
    RxAlways,
    RxRandom,
    RxPeriodic
  } rx_style_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_item_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = 1'b0;
  logic [7:0] cfg_data_i  = '0;

  utf8_to_single_byte_charset_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial forever #5 clk_i = ~clk_i;

  // encoder model state
  logic [23:0] map_model [MapDepth];
  logic [7:0]  held_bytes [3];
  int          held_cnt    = 0;
  int          held_need   = 0;
  logic [1:0]  mode_model  = ModeIdentity;
  logic [7:0]  count_model = '0;

  in_item_t    send_q [$];
  out_item_t   expected_charset_q [$];
  logic [15:0] key_plan [MapDepth];

  int text_items     = 0;
  int map_items      = 0;
  int bytes_checked  = 0;
  int cfg_writes     = 0;
  int errors         = 0;
  int idle_cycles    = 0;
  out_item_t want;

  function automatic logic [7:0] charset_of(input logic [20:0] cp);
    int lo;
    int hi;
    int mid;
    logic [15:0] key;
    lo = 0;
    if (cp < AsciiLimit) return cp[7:0];
    if (mode_model == ModeIdentity) return (cp <= Latin1Max) ? cp[7:0] : SubstByte;
    if (mode_model != ModeTable || cp > BmpMax) return SubstByte;
    hi = (count_model > MapDepth) ? MapDepth : count_model;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      key = map_model[mid][23:8];
      if (cp < key) begin
        hi = mid;
      end else if (cp > key) begin
        lo = mid + 1;
      end else begin
        return map_model[mid][7:0];
      end
    end
    return SubstByte;
  endfunction

  // continuation bits are taken as they are, never checked
  task automatic decode_seq(input logic [3:0][7:0] seq, input int len, inout int pos,
                            output logic [20:0] cp);
    logic [7:0] c;
    c = seq[pos];
    pos++;
    cp = {13'd0, c};
    if ((c & Lead2Mask) == Lead2Val && pos < len) begin
      cp = {10'd0, c[4:0], seq[pos][5:0]};
      pos += 1;
    end else if ((c & Lead3Mask) == Lead3Val && pos + 1 < len) begin
      cp = {5'd0, c[3:0], seq[pos][5:0], seq[pos+1][5:0]};
      pos += 2;
    end else if ((c & Lead4Mask) == Lead4Val && pos + 2 < len) begin
      cp = {c[2:0], seq[pos][5:0], seq[pos+1][5:0], seq[pos+2][5:0]};
      pos += 3;
    end
  endtask

  task automatic push_charset_byte(input logic [7:0] b, input logic last, input logic done);
    out_item_t r;
    r.out_byte  = b;
    r.run_last  = last;
    r.text_done = done;
    expected_charset_q.push_back(r);
  endtask

  task automatic predict_encoder(input in_item_t it);
    logic [3:0][7:0] seq;
    logic [7:0] codes [4];
    logic [20:0] cp;
    logic [7:0] c;
    int len;
    int pos;
    int n;
    if (it.req_type == ReqMapWrite) begin
      map_model[it.entry_index] = {it.entry_code_point, it.entry_byte};
    end else begin
      c = it.text_byte;
      seq = '0;
      for (int i = 0; i < held_cnt; i++) seq[i] = held_bytes[i];
      seq[held_cnt] = c;
      len = held_cnt + 1;
      if (it.text_end) begin
        // reparse from the start, a lead without enough bytes stands for itself
        pos = 0;
        n = 0;
        while (pos < len) begin
          decode_seq(seq, len, pos, cp);
          codes[n] = charset_of(cp);
          n++;
        end
        for (int i = 0; i < n; i++) push_charset_byte(codes[i], i == n - 1, i == n - 1);
        held_cnt  = 0;
        held_need = 0;
      end else if (held_cnt == 0) begin
        if ((c & Lead2Mask) == Lead2Val) held_need = 1;
        else if ((c & Lead3Mask) == Lead3Val) held_need = 2;
        else if ((c & Lead4Mask) == Lead4Val) held_need = 3;
        else held_need = 0;
        if (held_need == 0) begin
          push_charset_byte(charset_of({13'd0, c}), 1'b1, 1'b0);
        end else begin
          held_bytes[0] = c;
          held_cnt = 1;
        end
      end else if (len >= 1 + held_need) begin
        pos = 0;
        decode_seq(seq, len, pos, cp);
        push_charset_byte(charset_of(cp), 1'b1, 1'b0);
        held_cnt  = 0;
        held_need = 0;
      end else begin
        held_bytes[held_cnt] = c;
        held_cnt++;
      end
    end
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (send_q.size() != 0) begin
        in_data_i  <= send_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall style is drawn anew every segment
  rx_style_e rx_style = RxAlways;
  int        seg_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_style    <= RxAlways;
      seg_left    <= 0;
    end else begin
      if (seg_left == 0) begin
        rx_style <= rx_style_e'($urandom_range(0, 2));
        seg_left <= $urandom_range(20, 150);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (rx_style)
        RxAlways: out_ready_i <= 1'b1;
        RxRandom: out_ready_i <= 1'($urandom_range(0, 1));
        default:  out_ready_i <= (seg_left % 8) >= 5;
      endcase
    end
  end

  // monitor: model update, output check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgCharsetMode) mode_model = cfg_data_i[1:0];
        else count_model = cfg_data_i;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_charset_q.size() == 0) begin
          $error("transfer with nothing expected: out_byte %0h", out_data_o.out_byte);
          errors++;
        end else begin
          want = expected_charset_q.pop_front();
          bytes_checked++;
          if (out_data_o.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_data_o.out_byte);
            errors++;
          end
          if (out_data_o.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, out_data_o.run_last);
            errors++;
          end
          if (out_data_o.text_done !== want.text_done) begin
            $error("text_done: expected %0b, got %0b", want.text_done, out_data_o.text_done);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) predict_encoder(in_data_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("timeout: %0d cycles without a transfer", StallLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic queue_text_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.req_type         = ReqText;
    it.text_byte        = b;
    it.text_end         = last;
    it.entry_index      = 7'($urandom);
    it.entry_code_point = 16'($urandom);
    it.entry_byte       = 8'($urandom);
    send_q.push_back(it);
    text_items++;
  endtask

  task automatic queue_map_entry(input logic [6:0] idx, input logic [15:0] key,
                                 input logic [7:0] val);
    in_item_t it;
    it.req_type         = ReqMapWrite;
    it.text_byte        = 8'($urandom);
    it.text_end         = 1'($urandom);
    it.entry_index      = idx;
    it.entry_code_point = key;
    it.entry_byte       = val;
    send_q.push_back(it);
    key_plan[idx] = key;
    map_items++;
  endtask

  task automatic queue_code_point(input logic [20:0] cp, input logic last);
    if (cp < AsciiLimit) begin
      queue_text_byte(cp[7:0], last);
    end else if (cp < 21'h800) begin
      queue_text_byte({Lead2Val[7:5], cp[10:6]}, 1'b0);
      queue_text_byte({2'b10, cp[5:0]}, last);
    end else if (cp < 21'h10000) begin
      queue_text_byte({Lead3Val[7:4], cp[15:12]}, 1'b0);
      queue_text_byte({2'b10, cp[11:6]}, 1'b0);
      queue_text_byte({2'b10, cp[5:0]}, last);
    end else begin
      queue_text_byte({Lead4Val[7:3], cp[20:18]}, 1'b0);
      queue_text_byte({2'b10, cp[17:12]}, 1'b0);
      queue_text_byte({2'b10, cp[11:6]}, 1'b0);
      queue_text_byte({2'b10, cp[5:0]}, last);
    end
  endtask

  // mostly well-formed code points, some stray bytes and cut-short sequences
  task automatic queue_random_texts(input int n_texts, input logic map_noise);
    int n_cp;
    int r;
    int sel;
    int k;
    logic last;
    logic [7:0] lead;
    for (int t = 0; t < n_texts; t++) begin
      n_cp = $urandom_range(1, 4);
      for (int j = 0; j < n_cp; j++) begin
        last = (j == n_cp - 1);
        if (map_noise && $urandom_range(0, 99) < 4) begin
          queue_map_entry(7'($urandom), 16'($urandom), 8'($urandom));
        end
        r = $urandom_range(0, 99);
        if (r < 28) begin
          queue_code_point(21'($urandom_range(0, 8'h7F)), last);
        end else if (r < 50) begin
          queue_code_point({5'd0, key_plan[7'($urandom_range(0, MapDepth - 1))]}, last);
        end else if (r < 65) begin
          queue_code_point(21'($urandom_range(8'h80, 16'h7FF)), last);
        end else if (r < 77) begin
          queue_code_point(21'($urandom_range(16'h800, 16'hFFFF)), last);
        end else if (r < 83) begin
          queue_code_point(21'($urandom_range(21'h10000, 21'h1FFFFF)), last);
        end else if (r < 91) begin
          queue_text_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                               : 8'($urandom_range(8'hF8, 8'hFF)), last);
        end else if (r < 96) begin
          sel = $urandom_range(0, 2);
          case (sel)
            0:       lead = {3'b110, 5'($urandom)};
            1:       lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
          endcase
          k = $urandom_range(0, sel);
          queue_text_byte(lead, last && k == 0);
          for (int i = 0; i < k; i++) queue_text_byte({2'b10, 6'($urandom)}, last && i == k - 1);
        end else begin
          queue_text_byte(8'($urandom), last);
        end
      end
    end
  endtask

  task automatic wait_for_drain();
    while (send_q.size() != 0 || in_valid_i || expected_charset_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_register(input logic idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // map writes give no result, so the block may still be busy after the last one
  task automatic apply_setting(input logic [1:0] mode, input logic [7:0] count);
    wait_for_drain();
    repeat (SettleCycles) @(posedge clk_i);
    write_register(CfgCharsetMode, {6'd0, mode});
    write_register(CfgMapCount, count);
  endtask

  initial begin
    for (int i = 0; i < MapDepth; i++) begin
      map_model[i] = '0;
      key_plan[i]  = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity mode straight out of reset
    queue_text_byte(8'h00, 1'b0);
    queue_text_byte(8'h7F, 1'b0);
    queue_code_point(21'h80, 1'b0);
    queue_text_byte(8'hC3, 1'b0);
    queue_map_entry(7'd5, 16'h0000, 8'h00);   // lands between the two bytes
    queue_text_byte(8'hBF, 1'b0);
    queue_code_point(21'h100, 1'b0);
    queue_code_point(21'h20AC, 1'b0);
    queue_code_point(21'h1F600, 1'b0);
    queue_text_byte(8'h80, 1'b0);
    queue_text_byte(8'hBF, 1'b0);
    queue_text_byte(8'hF8, 1'b0);
    queue_text_byte(8'hFF, 1'b0);
    queue_text_byte(8'hE2, 1'b0);
    queue_text_byte(8'h82, 1'b1);
    queue_text_byte(8'hF0, 1'b0);
    queue_text_byte(8'h9F, 1'b0);
    queue_text_byte(8'h98, 1'b1);
    queue_text_byte(8'h41, 1'b1);

    // fill every slot with ascending keys from 0x80 up to 0xFFFF
    for (int i = 0; i < MapDepth; i++) begin
      queue_map_entry(7'(i), (i == MapDepth - 1) ? 16'hFFFF : 16'(16'h0080 + i * 16'h0200),
                      (i == 0) ? 8'h00 : (i == MapDepth - 1) ? 8'hFF : 8'($urandom));
    end

    apply_setting(ModeTable, 8'(MapDepth));
    queue_code_point(21'h80, 1'b0);
    queue_code_point(21'hFFFF, 1'b0);
    queue_code_point(21'h81, 1'b0);
    queue_code_point(21'h10000, 1'b0);
    queue_text_byte(8'h41, 1'b1);
    queue_random_texts(2, 1'b0);
    // let everything drain before more text
    wait_for_drain();
    queue_random_texts(2, 1'b1);

    apply_setting(ModeTable, 8'd0);
    queue_random_texts(2, 1'b0);
    apply_setting(ModeTable, 8'd1);
    queue_random_texts(2, 1'b0);
    apply_setting(ModeTable, 8'hFF);
    queue_random_texts(2, 1'b0);
    apply_setting(ModeTable, 8'($urandom_range(2, MapDepth - 1)));
    queue_random_texts(3, 1'b1);
    apply_setting(ModeAscii, 8'($urandom_range(0, MapDepth)));
    queue_random_texts(2, 1'b0);
    apply_setting(ModeSpare, 8'(MapDepth));
    queue_random_texts(2, 1'b0);
    apply_setting(ModeIdentity, 8'(MapDepth));
    queue_random_texts(2, 1'b0);

    wait_for_drain();
    repeat (SettleCycles) @(posedge clk_i);
    $display("sent %0d text bytes and %0d map entry writes, checked %0d output bytes",
             text_items, map_items, bytes_checked);
    $display("%0d register writes: table, identity, ascii and spare modes, map sizes 0 to 255",
             cfg_writes);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/u8sb_pkg.sv
rtl/u8sb_lookup.sv
rtl/utf8_to_single_byte_charset_core.sv
tb/utf8_to_single_byte_charset_core_tb.sv
